// ----- rtl/lfpq_pkg.sv -----
// Shared types and constants for the lexicographic FIFO priority queue.
// Used by lfpq_cell and lexicographic_fifo_priority_queue_core; no dependencies.
package lfpq_pkg;

  localparam int KEY_FIELDS = 3;
  localparam int KEY_W      = 16;
  localparam int HANDLE_W   = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 7;
  localparam int KEYS_W     = KEY_FIELDS * KEY_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] CFG_KEYS_IN_USE   = 2'd0;
  localparam logic [1:0] CFG_RELIABLE_MASK = 2'd1;
  localparam logic [1:0] CFG_UNSAFE_PRUNE  = 2'd2;

  // The key is stored with the first evaluator value in the top bits, so a
  // plain magnitude compare of the whole word is the lexicographic order.
  typedef struct packed {
    logic [KEYS_W-1:0]   key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   ins_here;
    entry_t ent;
  } nbr_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic ins;
    logic rem;
    logic clr;
  } cell_ctl_t;

endpackage

// ----- rtl/lfpq_cell.sv -----
// One cell of the sorted chain: holds one entry and its valid bit.
// Depends on lfpq_pkg; instantiated in a row by the top level.
module lfpq_cell (
  input  logic              clk,
  input  logic              rst,
  input  lfpq_pkg::cell_ctl_t ctl,
  input  lfpq_pkg::entry_t  new_ent,
  input  lfpq_pkg::nbr_t    left,
  input  lfpq_pkg::nbr_t    right,
  output lfpq_pkg::nbr_t    self
);
  import lfpq_pkg::*;

  logic   valid;
  entry_t ent;

  // A new entry belongs at or before this cell when the cell is empty or its
  // key is strictly greater, so equal keys keep their arrival order.
  assign self.valid    = valid;
  assign self.ent      = ent;
  assign self.ins_here = !valid || (ent.key > new_ent.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      valid <= valid || left.valid;
    end else if (ctl.rem) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left.ins_here) begin
        ent <= left.ent;
      end else if (self.ins_here) begin
        ent <= new_ent;
      end
    end else if (ctl.rem) begin
      ent <= right.ent;
    end
  end

endmodule

// ----- rtl/lexicographic_fifo_priority_queue_core.sv -----
// Top level of the lexicographic FIFO priority queue: a sorted chain of cells
// with command decode, dead-end query and the result register.
// Depends on lfpq_pkg and lfpq_cell.
//
// Usage: each command enters as one transfer on the s_ channel (command in
// s_tuser, keys and handle in s_tdata) and yields exactly one result transfer
// on the m_ channel. The entries sit sorted in a row of QUEUE_DEPTH cells with
// the minimum in the first cell. The new key is broadcast to every cell, each
// cell compares it with its own key, and all cells update together: each holds,
// takes the new entry or takes its neighbor's entry, so the cost of an insert
// or a remove does not depend on the fill level. The result is registered and
// turns valid in the cycle after the input transfer; the block takes one
// command per cycle as long as results are taken. The result register decides
// the rate: a new command is accepted whenever the result register is empty or
// is being emptied in the same cycle, so a stalled receiver holds off the input
// after one waiting result.
// Reset empties the queue, drops any pending result and loads the register
// defaults: one key in use, no reliable evaluators, unsafe pruning on.
// Configuration writes on cfg_we take effect on the next command.
module lexicographic_fifo_priority_queue_core #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key_first, key_second, key_third, entry_handle
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // removed_handle, status, is_empty, occupancy,
                                 // dead_end, zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  import lfpq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [1:0]          keys_in_use;
  logic [KEY_FIELDS-1:0] reliable_mask;
  logic                prune_first;

  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  logic                fire;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_W-1:0]    key_in [KEY_FIELDS];
  logic [KEY_W-1:0]    key_used [KEY_FIELDS];
  logic [KEY_FIELDS-1:0] used;
  logic [KEY_FIELDS-1:0] inf;
  logic                full;
  logic                empty;
  logic                dead;
  cell_ctl_t           ctl;
  entry_t              new_ent;
  nbr_t                cells [QUEUE_DEPTH];
  nbr_t                edge_nbr;

  logic [HANDLE_W-1:0] removed_handle;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] removed_next;
  logic [STATUS_W-1:0] status_next;
  logic                dead_end;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;
  assign cmd      = s_tuser;

  assign key_in[0] = s_tdata[15:0];
  assign key_in[1] = s_tdata[31:16];
  assign key_in[2] = s_tdata[47:32];

  // Key position i is used when i < k, with k clamped to 1..KEY_FIELDS.
  assign used[0] = 1'b1;
  assign used[1] = keys_in_use >= 2'd2;
  assign used[2] = keys_in_use >= 2'd3;

  always_comb begin
    for (int i = 0; i < KEY_FIELDS; i++) begin
      key_used[i] = used[i] ? key_in[i] : '0;
      inf[i]      = used[i] && (key_in[i] == '1);
    end
  end

  assign new_ent.key    = {key_used[0], key_used[1], key_used[2]};
  assign new_ent.handle = s_tdata[63:48];

  assign full  = cnt == CNT_W'(QUEUE_DEPTH);
  assign empty = cnt == '0;

  assign ctl.ins = fire && (cmd == CMD_INSERT) && !full;
  assign ctl.rem = fire && (cmd == CMD_REMOVE) && !empty;
  assign ctl.clr = fire && (cmd == CMD_CLEAR);

  assign dead = (|(inf & reliable_mask)) || (prune_first && inf[0])
                || ((inf | ~used) == '1);

  assign edge_nbr = '{valid: 1'b0, ins_here: 1'b0, ent: new_ent};

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    nbr_t left_n;
    nbr_t right_n;
    if (g == 0) begin : g_first
      assign left_n = '{valid: 1'b1, ins_here: 1'b0, ent: new_ent};
    end else begin : g_mid_left
      assign left_n = cells[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_n = edge_nbr;
    end else begin : g_mid_right
      assign right_n = cells[g+1];
    end
    lfpq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .new_ent (new_ent),
      .left    (left_n),
      .right   (right_n),
      .self    (cells[g])
    );
  end

  always_comb begin
    cnt_next     = cnt;
    removed_next = '0;
    status_next  = STATUS_OK;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          removed_next = cells[0].ent.handle;
          cnt_next     = cnt - 1'b1;
        end
      end
      CMD_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_in_use    <= 2'd1;
      reliable_mask  <= '0;
      prune_first    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEYS_IN_USE:   keys_in_use    <= cfg_data[1:0];
        CFG_RELIABLE_MASK: reliable_mask  <= cfg_data[KEY_FIELDS-1:0];
        CFG_UNSAFE_PRUNE:  prune_first    <= cfg_data[0];
        default:           keys_in_use    <= keys_in_use;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else if (fire) begin
      cnt      <= cnt_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      removed_handle <= removed_next;
      status         <= status_next;
      dead_end       <= (cmd == CMD_QUERY) && dead;
    end
  end

  assign m_tdata = {5'd0, dead_end, OCC_W'(cnt), (cnt == '0), status, removed_handle};

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    cells[0].valid == (cnt != '0))
    else $error("first cell valid bit disagrees with the entry count");

  a_tail_full: assert property (@(posedge clk) disable iff (rst)
    cells[QUEUE_DEPTH-1].valid == (cnt == CNT_W'(QUEUE_DEPTH)))
    else $error("last cell valid bit disagrees with a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> cnt == $past(cnt) + 1'b1)
    else $error("accepted insert did not grow the queue");

endmodule

// ----- test/lfpq_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the lexicographic FIFO priority queue: it watches the command,
// result and register channels, predicts every result and compares it.
// Depends on lfpq_pkg for field widths, command, status and register codes.
module lfpq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // key_first, key_second, key_third, entry_handle
  input  logic [1:0]  s_tuser,   // cmd
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // removed_handle, status, is_empty, occupancy,
                                 // dead_end, zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  output int          failures,
  output int          outstanding,
  output int          compared
);
  import lfpq_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [KEY_W-1:0] KEY_INF = '1;

  typedef struct packed {
    logic [HANDLE_W-1:0] removed_handle;
    logic [STATUS_W-1:0] status;
    logic                is_empty;
    logic [OCC_W-1:0]    occupancy;
    logic                dead_end;
  } outcome_t;

  // Sorted copy of the queue contents, minimum in slot 0. The key is packed
  // with the first value on top so that a magnitude compare is lexicographic.
  logic [KEYS_W-1:0]   held_keys    [DEPTH];
  logic [HANDLE_W-1:0] held_handles [DEPTH];
  int                  held_count = 0;

  logic [1:0] keys_reg     = 2'd1;
  logic [2:0] reliable_reg = 3'd0;
  logic       unsafe_reg   = 1'b1;

  outcome_t queue_outcomes[$];
  int       fail_total = 0;
  int       pending_total = 0;
  int       compare_total = 0;
  int       printed = 0;

  assign failures    = fail_total;
  assign outstanding = pending_total;
  assign compared    = compare_total;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_total++;
    if (printed < 40) begin
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      printed++;
    end
  endtask

  function automatic outcome_t apply_queue_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [63:0] data);
    outcome_t            res;
    int                  k;
    int                  pos;
    logic [KEY_W-1:0]    keys [KEY_FIELDS];
    logic [KEYS_W-1:0]   entry_key;
    logic [HANDLE_W-1:0] handle;
    logic                all_inf;
    res = '0;
    k = (keys_reg == 2'd0) ? 1 : int'(keys_reg);
    for (int i = 0; i < KEY_FIELDS; i++) begin
      keys[i] = (i < k) ? data[KEY_W*i +: KEY_W] : '0;
    end
    entry_key = {keys[0], keys[1], keys[2]};
    handle = data[KEYS_W +: HANDLE_W];
    case (cmd)
      CMD_INSERT: begin
        if (held_count >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_keys[pos] <= entry_key) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_keys[i]    = held_keys[i-1];
            held_handles[i] = held_handles[i-1];
          end
          held_keys[pos]    = entry_key;
          held_handles[pos] = handle;
          held_count++;
        end
      end
      CMD_REMOVE: begin
        if (held_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.removed_handle = held_handles[0];
          for (int i = 0; i + 1 < held_count; i++) begin
            held_keys[i]    = held_keys[i+1];
            held_handles[i] = held_handles[i+1];
          end
          held_count--;
        end
      end
      CMD_CLEAR: begin
        held_count = 0;
      end
      default: begin
        all_inf = 1'b1;
        for (int i = 0; i < k; i++) begin
          if (keys[i] == KEY_INF && reliable_reg[i]) res.dead_end = 1'b1;
          if (keys[i] != KEY_INF) all_inf = 1'b0;
        end
        if (unsafe_reg && keys[0] == KEY_INF) res.dead_end = 1'b1;
        if (all_inf) res.dead_end = 1'b1;
      end
    endcase
    res.is_empty  = (held_count == 0);
    res.occupancy = held_count[OCC_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      held_count   = 0;
      keys_reg     = 2'd1;
      reliable_reg = 3'd0;
      unsafe_reg   = 1'b1;
      queue_outcomes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (queue_outcomes.size() == 0) begin
          report_mismatch("result with no command waiting", m_tdata, '0);
        end else begin
          want = queue_outcomes[0];
          queue_outcomes.delete(0);
          compare_total++;
          if (m_tdata[15:0] !== want.removed_handle)
            report_mismatch("removed_handle", 32'(m_tdata[15:0]),
                            32'(want.removed_handle));
          if (m_tdata[17:16] !== want.status)
            report_mismatch("status", 32'(m_tdata[17:16]), 32'(want.status));
          if (m_tdata[18] !== want.is_empty)
            report_mismatch("is_empty", 32'(m_tdata[18]), 32'(want.is_empty));
          if (m_tdata[25:19] !== want.occupancy)
            report_mismatch("occupancy", 32'(m_tdata[25:19]), 32'(want.occupancy));
          if (m_tdata[26] !== want.dead_end)
            report_mismatch("dead_end", 32'(m_tdata[26]), 32'(want.dead_end));
          if (m_tdata[31:27] !== 5'd0)
            report_mismatch("zero fill", 32'(m_tdata[31:27]), '0);
        end
      end
      if (s_tvalid && s_tready) begin
        queue_outcomes.insert(queue_outcomes.size(), apply_queue_command(s_tuser, s_tdata));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEYS_IN_USE:   keys_reg     = cfg_data[1:0];
          CFG_RELIABLE_MASK: reliable_reg = cfg_data[2:0];
          CFG_UNSAFE_PRUNE:  unsafe_reg   = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending_total = queue_outcomes.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Top of the priority queue testbench: clock, reset, command and register
// stimulus with random idling, and the verdict. Depends on lfpq_pkg,
// lfpq_checker and lexicographic_fifo_priority_queue_core.
module testbench;
  import lfpq_pkg::*;

  localparam int LIMIT = 400000;
  localparam logic [KEY_W-1:0] KEY_INF = '1;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_QUERY} mix_t;

  typedef struct {
    logic [1:0] keys;
    logic [2:0] mask;
    logic       unsafe;
    mix_t       mix;
    int         tx_pct;
    int         rx_pct;
    int         items;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [2:0]  cfg_data = '0;

  int failures;
  int outstanding;
  int compared;
  int cycles = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int settings_used = 0;
  int sent_by_cmd [4] = '{0, 0, 0, 0};

  always #6 clk = ~clk;

  lexicographic_fifo_priority_queue_core #(
    .QUEUE_DEPTH(64)
  ) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lfpq_checker scoreboard (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding), .compared(compared)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Result receiver: mostly short stalls, now and then a long one.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready = 1'b0;
        hold--;
      end else if ($urandom_range(99) < rx_stall_pct) begin
        m_tready = 1'b0;
        hold = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 0);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_key(input bit lean_inf);
    int r;
    r = $urandom_range(9);
    if (lean_inf && r < 5) return KEY_INF;
    case (r)
      0, 1, 2, 3: return KEY_W'($urandom_range(3));
      4, 5:       return KEY_INF;
      6:          return KEY_INF - 1'b1;
      default:    return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input mix_t mix);
    int r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  return (r < 85) ? CMD_INSERT : (r < 93) ? CMD_REMOVE : CMD_QUERY;
      MIX_DRAIN: return (r < 20) ? CMD_INSERT : (r < 85) ? CMD_REMOVE :
                        (r < 87) ? CMD_CLEAR : CMD_QUERY;
      MIX_QUERY: return (r < 30) ? CMD_INSERT : (r < 45) ? CMD_REMOVE :
                        (r < 47) ? CMD_CLEAR : CMD_QUERY;
      default:   return (r < 45) ? CMD_INSERT : (r < 80) ? CMD_REMOVE :
                        (r < 83) ? CMD_CLEAR : CMD_QUERY;
    endcase
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k1,
                              input logic [KEY_W-1:0] k2, input logic [KEY_W-1:0] k3,
                              input logic [HANDLE_W-1:0] handle);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_gap_pct)
      gap = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) begin
        s_tdata = {$urandom, $urandom};
        s_tuser = CMD_W'($urandom);
        @(negedge clk);
      end
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {handle, k3, k2, k1};
    do @(posedge clk); while (!s_tready);
    sent_by_cmd[cmd]++;
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [2:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Registers change only with the queue idle and every result delivered.
  task automatic load_settings(input logic [1:0] keys, input logic [2:0] mask,
                               input logic unsafe);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    write_reg(CFG_KEYS_IN_USE, keys);
    write_reg(CFG_RELIABLE_MASK, mask);
    write_reg(CFG_UNSAFE_PRUNE, {2'b00, unsafe});
    settings_used++;
  endtask

  initial begin
    phase_t             plan [6];
    logic [CMD_W-1:0]   cmd;
    logic [HANDLE_W-1:0] handle;
    int                 r;

    plan[0] = '{2'd0, 3'd7, 1'b0, MIX_BALANCED, 30, 30, 70};
    plan[1] = '{2'd3, 3'd0, 1'b0, MIX_FILL,      0,  0, 110};
    plan[2] = '{2'd3, 3'd7, 1'b1, MIX_DRAIN,    40, 50, 90};
    plan[3] = '{2'd2, 3'd5, 1'b1, MIX_QUERY,    20, 60, 80};
    plan[4] = '{2'd1, 3'd2, 1'b0, MIX_BALANCED, 10, 10, 90};
    plan[5] = '{2'($urandom), 3'($urandom), 1'($urandom), MIX_BALANCED, 30, 30, 90};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset register values: one key, unsafe pruning.
    send_command(CMD_REMOVE, 16'd0, 16'd0, 16'd0, 16'd0);
    send_command(CMD_QUERY, KEY_INF, 16'd0, 16'd0, 16'd0);
    send_command(CMD_QUERY, 16'd0, KEY_INF, KEY_INF, 16'd0);
    send_command(CMD_INSERT, 16'd5, 16'd9, 16'd9, 16'd1);
    send_command(CMD_INSERT, 16'd5, KEY_INF, 16'd0, 16'd2);
    send_command(CMD_INSERT, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_command(CMD_INSERT, KEY_INF, KEY_INF, KEY_INF, 16'h0000);
    send_command(CMD_INSERT, 16'd3, 16'd0, 16'd0, 16'hAAAA);
    repeat (6) send_command(CMD_REMOVE, 16'd0, 16'd0, 16'd0, 16'd0);
    send_command(CMD_INSERT, 16'd7, 16'd0, 16'd0, 16'h1234);
    send_command(CMD_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0);
    send_command(CMD_REMOVE, 16'd0, 16'd0, 16'd0, 16'd0);

    // Three keys: ties broken by later fields, then by arrival.
    load_settings(2'd3, 3'd0, 1'b0);
    send_command(CMD_INSERT, 16'd1, 16'd2, 16'd3, 16'd10);
    send_command(CMD_INSERT, 16'd1, 16'd2, 16'd2, 16'd11);
    send_command(CMD_INSERT, 16'd1, 16'd1, KEY_INF, 16'd12);
    send_command(CMD_INSERT, 16'd1, 16'd2, 16'd3, 16'd13);
    send_command(CMD_QUERY, KEY_INF, KEY_INF, KEY_INF, 16'd0);
    send_command(CMD_QUERY, KEY_INF, 16'd0, 16'd0, 16'd0);
    load_settings(2'd3, 3'd4, 1'b0);
    send_command(CMD_QUERY, 16'd0, 16'd0, KEY_INF, 16'd0);

    foreach (plan[p]) begin
      load_settings(plan[p].keys, plan[p].mask, plan[p].unsafe);
      tx_gap_pct   = plan[p].tx_pct;
      rx_stall_pct = plan[p].rx_pct;
      for (int i = 0; i < plan[p].items; i++) begin
        cmd = pick_cmd(plan[p].mix);
        r = $urandom_range(19);
        handle = (r == 0) ? '0 : (r == 1) ? '1 : HANDLE_W'($urandom);
        send_command(cmd, pick_key(cmd == CMD_QUERY), pick_key(cmd == CMD_QUERY),
                     pick_key(cmd == CMD_QUERY), handle);
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("testbench: %0d commands sent (%0d insert, %0d remove, %0d clear, %0d query)",
             sent_by_cmd[CMD_INSERT] + sent_by_cmd[CMD_REMOVE] + sent_by_cmd[CMD_CLEAR]
             + sent_by_cmd[CMD_QUERY], sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_REMOVE],
             sent_by_cmd[CMD_CLEAR], sent_by_cmd[CMD_QUERY]);
    $display("testbench: %0d results compared across %0d register settings, %0d mismatches",
             compared, settings_used + 1, failures);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lfpq_pkg.sv
rtl/lfpq_cell.sv
rtl/lexicographic_fifo_priority_queue_core.sv
test/lfpq_checker.sv
test/testbench.sv
